>>> rtl/srtf_pkg.sv
// Shared types and constants for the SRTF process scheduler.
// No dependencies; imported by the scheduler top level.
package srtf_pkg;

	localparam int TIME_W  = 24;
	localparam int BURST_W = 16;
	localparam int PID_W   = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// One process table entry as held in the table memory
	typedef struct packed {
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] remaining;
	} proc_entry_t;

	localparam int ENTRY_W = $bits(proc_entry_t);

	// One result transaction
	typedef struct packed {
		logic              load_error;
		logic              ran;
		logic [PID_W-1:0]  proc_id;
		logic              finished;
		logic [TIME_W-1:0] done_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] wait_time;
		logic [TIME_W-1:0] time_now;
		logic              all_done;
	} result_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/srtf_mem.sv
// Process table memory: one write port, one read port, registered read data.
// No dependencies.
module srtf_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/srtf_process_scheduler_top.sv
// Top level of the SRTF process scheduler: sequencer, scan logic and result register.
// Depends on srtf_pkg and srtf_mem.
//
// Usage: input transactions carry cmd, arrival and burst on an in_valid/in_ready
// channel. A load (cmd 0) stores a process in the next free slot of the table
// memory; a zero burst or a full table is refused with load_error. A tick (cmd 1)
// reads every loaded slot from the table memory, one per cycle, keeps the arrived,
// unfinished process with the least remaining time (ties: earlier arrival, then
// lower slot), writes back its decremented remaining time and advances time.
// Every input transaction yields exactly one result transaction on the
// out_valid/out_ready channel.
// Steps: a load goes from acceptance straight to the result stage; a tick scans
// the loaded slots through the single read port of the table memory, then takes
// the registered read data, the write-back and the result stage. One item is
// worked on at a time; in_ready is high only when the sequencer is idle, so a new
// item is accepted only once the last one has gone to the result register. The
// result register holds a result while the receiver stalls; the next item may be
// accepted meanwhile, and its result waits until the register frees. Reset clears
// counts, time, finished marks and the result channel; table contents are not
// cleared since only loaded slots are read.
module srtf_process_scheduler_top #(
	parameter int MAX_PROCESSES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [23:0]            arrival,
	input  logic [15:0]            burst,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   load_error,
	output logic                   ran,
	output logic [4:0]             proc_id,
	output logic                   finished,
	output logic [23:0]            done_time,
	output logic [23:0]            turnaround_time,
	output logic [23:0]            wait_time,
	output logic [23:0]            time_now,
	output logic                   all_done
);

	import srtf_pkg::*;

	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int PW    = CNT_W + PID_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCESSES);

	state_t state_q, state_d;

	logic [CNT_W-1:0]         loaded_q, finished_q;
	logic [TIME_W-1:0]        time_q;
	logic [MAX_PROCESSES-1:0] fin_marks_q;

	// Scan bookkeeping
	logic [CNT_W-1:0] issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	proc_entry_t      best_q;

	result_t res_q, out_q;
	result_t res_load, res_tick, res_out;

	// Memory ports
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr;
	proc_entry_t      mem_wdata, mem_rdata;

	logic              accept, load_ok, eligible, better;
	logic [TIME_W-1:0] time_next, turn, burst_ext;
	logic [PW-1:0]     pid_load, pid_run;

	srtf_mem #(
		.DEPTH (MAX_PROCESSES),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	// Decode
	assign accept    = in_valid && in_ready;
	assign load_ok   = (burst != '0) && (loaded_q < MAX_CNT);
	assign time_next = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
	assign pid_load  = PW'(loaded_q) + 1'b1;
	assign pid_run   = PW'(best_idx_q) + 1'b1;
	assign turn      = time_next - best_q.arrival;
	assign burst_ext = TIME_W'(best_q.burst);

	// Candidate compare on returned read data
	assign eligible = rd_vld_s1 && !fin_marks_q[rd_idx_s1] && (mem_rdata.arrival <= time_q);
	assign better   = !found_q
		|| (mem_rdata.remaining < best_q.remaining)
		|| ((mem_rdata.remaining == best_q.remaining)
			&& (mem_rdata.arrival < best_q.arrival));

	// Result contents for a load, for a tick, and as presented on the ports
	always_comb begin
		res_load            = '0;
		res_load.load_error = !load_ok;
		res_load.proc_id    = load_ok ? pid_load[PID_W-1:0] : '0;
		res_load.time_now   = time_q;
		res_tick            = '0;
		res_tick.time_now   = time_next;
		if (found_q) begin
			res_tick.ran     = 1'b1;
			res_tick.proc_id = pid_run[PID_W-1:0];
			if (best_q.remaining == BURST_W'(1)) begin
				res_tick.finished        = 1'b1;
				res_tick.done_time       = time_next;
				res_tick.turnaround_time = turn;
				res_tick.wait_time       = (turn >= burst_ext) ? turn - burst_ext : '0;
			end
		end
		res_out          = res_q;
		res_out.all_done = (loaded_q != '0) && (finished_q == loaded_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == CMD_LOAD) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!mem_re && !rd_vld_s1) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = best_q;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				mem_we    = in_valid && (cmd == CMD_LOAD) && load_ok;
				mem_waddr = loaded_q[IDX_W-1:0];
				mem_wdata = '{arrival: arrival, burst: burst, remaining: burst};
			end
			ST_SCAN: begin
				mem_re = issue_q < loaded_q;
			end
			ST_COMMIT: begin
				mem_we              = found_q;
				mem_wdata.remaining = best_q.remaining - 1'b1;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and architectural counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			finished_q  <= '0;
			time_q      <= '0;
			fin_marks_q <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			// Result register fills on emit when free, empties when taken
			if (state_q == ST_EMIT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					found_q <= 1'b0;
					if (accept && cmd == CMD_LOAD && load_ok) begin
						loaded_q                              <= loaded_q + 1'b1;
						fin_marks_q[loaded_q[IDX_W-1:0]] <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (eligible && better) begin
						found_q <= 1'b1;
					end
				end
				ST_COMMIT: begin
					time_q <= time_next;
					if (found_q && best_q.remaining == BURST_W'(1)) begin
						fin_marks_q[best_idx_q] <= 1'b1;
						finished_q              <= finished_q + 1'b1;
					end
				end
				ST_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Scan datapath and result assembly
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				issue_q <= '0;
				res_q   <= (accept && cmd == CMD_LOAD) ? res_load : '0;
			end
			ST_SCAN: begin
				if (mem_re) begin
					issue_q <= issue_q + 1'b1;
				end
				if (eligible && better) begin
					best_q     <= mem_rdata;
					best_idx_q <= rd_idx_s1;
				end
			end
			ST_COMMIT: begin
				res_q <= res_tick;
			end
			ST_EMIT: begin
				if (!out_valid || out_ready) begin
					out_q <= res_out;
				end
			end
			default: begin
			end
		endcase
	end

	// Result ports
	assign load_error      = out_q.load_error;
	assign ran             = out_q.ran;
	assign proc_id         = out_q.proc_id;
	assign finished        = out_q.finished;
	assign done_time       = out_q.done_time;
	assign turnaround_time = out_q.turnaround_time;
	assign wait_time       = out_q.wait_time;
	assign time_now        = out_q.time_now;
	assign all_done        = out_q.all_done;

endmodule

>>> tb/sv/srtf_process_scheduler_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SRTF process scheduler: drives load and tick transactions,
// predicts each result in-line and checks every result transaction in order.
// Depends on srtf_pkg and srtf_process_scheduler_top.
module srtf_process_scheduler_top_test;
	import srtf_pkg::*;

	localparam int NPROC        = 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              cmd      = CMD_LOAD;
	logic [TIME_W-1:0]  arrival = '0;
	logic [BURST_W-1:0] burst   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              load_error;
	logic              ran;
	logic [PID_W-1:0]  proc_id;
	logic              finished;
	logic [TIME_W-1:0] done_time;
	logic [TIME_W-1:0] turnaround_time;
	logic [TIME_W-1:0] wait_time;
	logic [TIME_W-1:0] time_now;
	logic              all_done;

	// Shadow process table and scheduler clock
	logic [TIME_W-1:0]  proc_arrival [NPROC];
	logic [BURST_W-1:0] proc_burst [NPROC];
	logic [BURST_W-1:0] proc_left [NPROC];
	logic               proc_done [NPROC];
	int                 n_loaded = 0;
	int                 n_done = 0;
	logic [TIME_W-1:0]  sched_time = '0;

	result_t due_results[$];
	result_t want;
	int      mismatch_count = 0;
	bit      idle_en = 1'b1;
	bit      hold_req = 1'b0;

	srtf_process_scheduler_top #(
		.MAX_PROCESSES(NPROC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.arrival(arrival),
		.burst(burst),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.load_error(load_error),
		.ran(ran),
		.proc_id(proc_id),
		.finished(finished),
		.done_time(done_time),
		.turnaround_time(turnaround_time),
		.wait_time(wait_time),
		.time_now(time_now),
		.all_done(all_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Limit on the whole run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Apply one transaction to the shadow scheduler and return the result it yields
	function automatic result_t schedule_step(input logic op, input logic [TIME_W-1:0] arr,
			input logic [BURST_W-1:0] bst);
		result_t           res;
		int                pick;
		bit                found;
		logic [TIME_W-1:0] done_at;
		logic [TIME_W-1:0] span;
		res = '0;
		pick = 0;
		found = 1'b0;
		if (op == CMD_LOAD) begin
			// zero burst or full table: refused, nothing stored
			if (bst == '0 || n_loaded >= NPROC) begin
				res.load_error = 1'b1;
			end else begin
				proc_arrival[n_loaded] = arr;
				proc_burst[n_loaded] = bst;
				proc_left[n_loaded] = bst;
				proc_done[n_loaded] = 1'b0;
				n_loaded++;
				res.proc_id = PID_W'(n_loaded);
			end
		end else begin
			// least remaining among arrived, unfinished; ties to earlier arrival, then lower slot
			for (int i = 0; i < n_loaded; i++) begin
				if (!proc_done[i] && proc_arrival[i] <= sched_time) begin
					if (!found || proc_left[i] < proc_left[pick] ||
							(proc_left[i] == proc_left[pick] &&
							proc_arrival[i] < proc_arrival[pick])) begin
						pick = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				res.ran = 1'b1;
				res.proc_id = PID_W'(pick + 1);
				proc_left[pick] = proc_left[pick] - 1'b1;
				if (proc_left[pick] == '0) begin
					done_at = (sched_time == TIME_MAX) ? TIME_MAX : sched_time + 1'b1;
					span = done_at - proc_arrival[pick];
					proc_done[pick] = 1'b1;
					n_done++;
					res.finished = 1'b1;
					res.done_time = done_at;
					res.turnaround_time = span;
					// negative wait only after saturation; clamp
					res.wait_time = (span >= TIME_W'(proc_burst[pick])) ?
						span - TIME_W'(proc_burst[pick]) : '0;
				end
			end
			if (sched_time != TIME_MAX)
				sched_time = sched_time + 1'b1;
		end
		res.time_now = sched_time;
		res.all_done = (n_loaded > 0 && n_done == n_loaded);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
	endtask

	// Offer one transaction, optionally after a random gap, and record its prediction
	task automatic send_item(input logic op, input logic [TIME_W-1:0] arr,
			input logic [BURST_W-1:0] bst);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		arrival <= arr;
		burst <= bst;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(schedule_step(op, arr, bst));
	endtask

	// Receiver: random stalls, plus a long hold when requested
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = due_results.pop_front();
				check_field("load_error", TIME_W'(load_error), TIME_W'(want.load_error));
				check_field("ran", TIME_W'(ran), TIME_W'(want.ran));
				check_field("proc_id", TIME_W'(proc_id), TIME_W'(want.proc_id));
				check_field("finished", TIME_W'(finished), TIME_W'(want.finished));
				check_field("done_time", done_time, want.done_time);
				check_field("turnaround_time", turnaround_time, want.turnaround_time);
				check_field("wait_time", wait_time, want.wait_time);
				check_field("time_now", time_now, want.time_now);
				check_field("all_done", TIME_W'(all_done), TIME_W'(want.all_done));
			end
		end
	end

	// Tick on an empty table: nothing runs, time still moves
	task automatic test_idle_tick();
		send_item(CMD_TICK, TIME_W'($urandom), BURST_W'($urandom));
	endtask

	task automatic test_zero_burst();
		send_item(CMD_LOAD, TIME_MAX, '0);
	endtask

	// Equal remaining and arrival: lower slot first; then all finished and an idle tick
	task automatic test_slot_tie_and_all_done();
		send_item(CMD_LOAD, '0, BURST_W'(1));
		send_item(CMD_LOAD, '0, BURST_W'(1));
		repeat (3) send_item(CMD_TICK, TIME_W'($urandom), BURST_W'($urandom));
	endtask

	// Late loads, both already arrived: the later slot with earlier arrival wins the tie
	task automatic test_arrival_tie();
		send_item(CMD_LOAD, sched_time - 1'b1, BURST_W'(2));
		send_item(CMD_LOAD, sched_time - 3'd3, BURST_W'(2));
		repeat (2) send_item(CMD_TICK, TIME_W'($urandom), BURST_W'($urandom));
	endtask

	// Largest burst, arrival at both ends of the range
	task automatic test_extreme_loads();
		send_item(CMD_LOAD, '0, '1);
		send_item(CMD_LOAD, TIME_MAX, '1);
	endtask

	// Fill the rest of the table with near-future arrivals, then one refused load
	task automatic test_table_full();
		while (n_loaded < NPROC)
			send_item(CMD_LOAD, sched_time + TIME_W'($urandom_range(0, 150)),
				BURST_W'($urandom_range(1, 50)));
		send_item(CMD_LOAD, TIME_W'($urandom), BURST_W'($urandom_range(1, 65535)));
	endtask

	// Mostly ticks; loads carry random fields, some with zero burst
	task automatic test_random_mix(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 4) != 0)
				send_item(CMD_TICK, TIME_W'($urandom), BURST_W'($urandom));
			else if ($urandom_range(0, 3) == 0)
				send_item(CMD_LOAD, TIME_W'($urandom), '0);
			else
				send_item(CMD_LOAD, TIME_W'($urandom), BURST_W'($urandom));
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		test_random_mix(40);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_tick();
		test_zero_burst();
		test_slot_tie_and_all_done();
		test_arrival_tie();
		test_extreme_loads();
		test_table_full();
		test_random_mix(700);
		test_output_backpressure();
		test_random_mix(380);
		// final stretch without idling on either side
		idle_en = 1'b0;
		test_random_mix(300);
		in_valid <= 1'b0;
		for (int w = 0; w < 100000 && due_results.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
